// ===== rtl/lbcd_pkg.sv =====
// ============================================================================
// LED blink code decoder package
// Shared widths, register indexes, reset values and the burst check result.
// ============================================================================
package lbcd_pkg;

    // Field widths fixed by the interface.
    localparam int STATUS_W  = 4;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Largest value of a saturating 16-bit counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BURST_HIGH_MIN = 2'd0,
        REG_BURST_HIGH_MAX = 2'd1,
        REG_MAX_CODE       = 2'd2,
        REG_WATCHDOG_TICKS = 2'd3
    } cfg_reg_t;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0]  BURST_HIGH_MIN_RST = 16'd75;
    localparam logic [COUNT_W-1:0]  BURST_HIGH_MAX_RST = 16'd85;
    localparam logic [STATUS_W-1:0] MAX_CODE_RST       = 4'd13;
    localparam logic [COUNT_W-1:0]  WATCHDOG_TICKS_RST = 16'd8000;

    // Outcome of checking one burst at a rising edge.
    typedef struct packed {
        logic                in_window;  // high time inside the window
        logic                code_ok;    // code is between 1 and max_code
        logic                changed;    // code becomes the new status
        logic [STATUS_W-1:0] code;       // rounded code, low bits
    } burst_result_t;

endpackage

// ===== rtl/lbcd_burst_check.sv =====
// ============================================================================
// LED blink code decoder burst check
// Checks the high time against the window, rounds the low time to a code,
// and compares the code with the history and the current status.
// ============================================================================
module lbcd_burst_check #(
    parameter int CODE_SHIFT    = 4,
    parameter int HISTORY_DEPTH = 3
) (
    input  logic [lbcd_pkg::COUNT_W-1:0]  high_total,
    input  logic [lbcd_pkg::COUNT_W-1:0]  low_sum,
    input  logic [lbcd_pkg::COUNT_W-1:0]  burst_high_min,
    input  logic [lbcd_pkg::COUNT_W-1:0]  burst_high_max,
    input  logic [lbcd_pkg::STATUS_W-1:0] max_code,
    input  logic [lbcd_pkg::STATUS_W-1:0] status_code,
    input  logic [lbcd_pkg::STATUS_W-1:0] code_history [HISTORY_DEPTH],
    output lbcd_pkg::burst_result_t       result
);

    localparam int SumW  = lbcd_pkg::COUNT_W + 1;
    localparam int CodeW = SumW - CODE_SHIFT;

    logic [SumW-1:0]  rounded;
    logic [CodeW-1:0] code_full;
    logic             all_same;

    // Round the low time to whole code units, keeping the full width.
    assign rounded   = {1'b0, low_sum} + (SumW'(1) << (CODE_SHIFT - 1));
    assign code_full = rounded[SumW-1:CODE_SHIFT];

    // The code must match every entry of the history.
    always_comb begin
        all_same = 1'b1;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (CodeW'(code_history[i]) != code_full) begin
                all_same = 1'b0;
            end
        end
    end

    // Assemble the check outcome.
    always_comb begin
        result.in_window = (high_total >= burst_high_min) && (high_total <= burst_high_max);
        result.code_ok   = (code_full != '0) && (code_full <= CodeW'(max_code));
        result.code      = code_full[lbcd_pkg::STATUS_W-1:0];
        result.changed   = result.in_window && result.code_ok && all_same &&
                           (code_full[lbcd_pkg::STATUS_W-1:0] != status_code);
    end

endmodule

// ===== rtl/led_blink_code_decoder_core.sv =====
// ============================================================================
// LED blink code decoder core
// Measures LED high and low runs, decodes the blink code into a status and
// clears the status when no valid burst arrives within the watchdog time.
// ============================================================================
// Usage:
//   Each slave word carries one sampled LED level (tdata bit 0). Every
//   accepted word produces exactly one master word with the status after
//   that tick, a status-changed flag and a watchdog-fired flag.
//   The result of a word accepted at one edge is registered and
//   presented on the master side from the next cycle. Throughput is one
//   word per cycle while the receiver keeps up; all per-tick work is
//   one pass of compares and saturating adds between the state registers
//   and the output register. When the receiver stalls, the output register
//   holds its word and s_tready stays high only while that word is being
//   taken, so no word is dropped or repeated.
//   Reset (aresetn low, synchronous) clears the run counters, the code
//   history and the status, arms the watchdog and loads the register
//   defaults 75, 85, 13 and 8000. The configuration port writes one
//   register per cycle while cfg_wr_en is high; write only when idle.
// ============================================================================
module led_blink_code_decoder_core #(
    parameter int CODE_SHIFT    = 4,
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [lbcd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [lbcd_pkg::COUNT_W-1:0]    cfg_wr_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] led_level, [7:1] zero
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata    // [3:0] status, [4] status_changed,
                                                       // [5] watchdog_fired, [7:6] zero
);

    localparam int StW = lbcd_pkg::STATUS_W;
    localparam int CnW = lbcd_pkg::COUNT_W;

    // Configuration registers.
    logic [CnW-1:0] burst_high_min_reg;
    logic [CnW-1:0] burst_high_max_reg;
    logic [StW-1:0] max_code_reg;
    logic [CnW-1:0] watchdog_ticks_reg;

    // Decoder state.
    logic           last_level_reg,     last_level_next;
    logic [CnW-1:0] run_ticks_reg,      run_ticks_next;
    logic [CnW-1:0] high_total_reg,     high_total_next;
    logic [CnW-1:0] low_total_reg,      low_total_next;
    logic [StW-1:0] code_history_reg    [HISTORY_DEPTH];
    logic [StW-1:0] code_history_next   [HISTORY_DEPTH];
    logic [StW-1:0] status_code_reg,    status_code_next;
    logic [CnW-1:0] watchdog_count_reg, watchdog_count_next;
    logic           watchdog_armed_reg, watchdog_armed_next;

    // Output register.
    logic           m_valid_reg;
    logic [StW-1:0] m_status_reg;
    logic           m_changed_reg;
    logic           m_fired_reg;

    logic           accept;
    logic           level;
    logic           rising;
    logic           falling;
    logic [CnW:0]   low_add;
    logic [CnW:0]   high_add;
    logic [CnW-1:0] low_sum;
    logic [CnW-1:0] high_sum;
    logic [CnW-1:0] wd_inc;
    logic           fed;
    logic           fired;
    logic           changed;

    lbcd_pkg::burst_result_t burst;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign level    = s_tdata[0];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_high_min_reg <= lbcd_pkg::BURST_HIGH_MIN_RST;
            burst_high_max_reg <= lbcd_pkg::BURST_HIGH_MAX_RST;
            max_code_reg       <= lbcd_pkg::MAX_CODE_RST;
            watchdog_ticks_reg <= lbcd_pkg::WATCHDOG_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (lbcd_pkg::cfg_reg_t'(cfg_addr))
                lbcd_pkg::REG_BURST_HIGH_MIN: burst_high_min_reg <= cfg_wr_data;
                lbcd_pkg::REG_BURST_HIGH_MAX: burst_high_max_reg <= cfg_wr_data;
                lbcd_pkg::REG_MAX_CODE:       max_code_reg       <= cfg_wr_data[StW-1:0];
                lbcd_pkg::REG_WATCHDOG_TICKS: watchdog_ticks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Edge detection and saturating run totals.
    assign rising   = level && !last_level_reg;
    assign falling  = !level && last_level_reg;
    assign low_add  = {1'b0, low_total_reg} + {1'b0, run_ticks_reg};
    assign high_add = {1'b0, high_total_reg} + {1'b0, run_ticks_reg};
    assign low_sum  = low_add[CnW] ? lbcd_pkg::COUNT_MAX : low_add[CnW-1:0];
    assign high_sum = high_add[CnW] ? lbcd_pkg::COUNT_MAX : high_add[CnW-1:0];

    // Burst check on the tick of the rising edge.
    lbcd_burst_check #(
        .CODE_SHIFT    (CODE_SHIFT),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_burst_check (
        .high_total     (high_total_reg),
        .low_sum        (low_sum),
        .burst_high_min (burst_high_min_reg),
        .burst_high_max (burst_high_max_reg),
        .max_code       (max_code_reg),
        .status_code    (status_code_reg),
        .code_history   (code_history_reg),
        .result         (burst)
    );

    assign fed     = rising && burst.in_window;
    assign changed = fed && burst.changed;
    assign wd_inc  = (watchdog_count_reg == lbcd_pkg::COUNT_MAX) ?
                     lbcd_pkg::COUNT_MAX : watchdog_count_reg + CnW'(1);
    assign fired   = !fed && watchdog_armed_reg && (wd_inc >= watchdog_ticks_reg);

    // Next state for one tick.
    always_comb begin
        last_level_next     = level;
        run_ticks_next      = (rising || falling) ? CnW'(1) :
                              (run_ticks_reg == lbcd_pkg::COUNT_MAX) ?
                              lbcd_pkg::COUNT_MAX : run_ticks_reg + CnW'(1);
        high_total_next     = high_total_reg;
        low_total_next      = low_total_reg;
        code_history_next   = code_history_reg;
        status_code_next    = status_code_reg;
        watchdog_count_next = watchdog_count_reg;
        watchdog_armed_next = watchdog_armed_reg;

        if (rising) begin
            high_total_next = '0;
            low_total_next  = '0;
        end else if (falling) begin
            high_total_next = high_sum;
        end

        // A valid code shifts into the history.
        if (fed && burst.code_ok) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                code_history_next[i] = code_history_reg[i + 1];
            end
            code_history_next[HISTORY_DEPTH - 1] = burst.code;
        end

        if (changed) begin
            status_code_next = burst.code;
        end

        // Watchdog: rearm on a valid burst, otherwise count while armed; on firing, disarm and clear the status.
        if (fed) begin
            watchdog_count_next = '0;
            watchdog_armed_next = 1'b1;
        end else if (watchdog_armed_reg) begin
            if (fired) begin
                watchdog_count_next = '0;
                watchdog_armed_next = 1'b0;
                status_code_next    = '0;
            end else begin
                watchdog_count_next = wd_inc;
            end
        end
    end

    // State registers, updated on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg     <= 1'b0;
            run_ticks_reg      <= '0;
            high_total_reg     <= '0;
            low_total_reg      <= '0;
            status_code_reg    <= '0;
            watchdog_count_reg <= '0;
            watchdog_armed_reg <= 1'b1;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                code_history_reg[i] <= '0;
            end
        end else if (accept) begin
            last_level_reg     <= last_level_next;
            run_ticks_reg      <= run_ticks_next;
            high_total_reg     <= high_total_next;
            low_total_reg      <= low_total_next;
            status_code_reg    <= status_code_next;
            watchdog_count_reg <= watchdog_count_next;
            watchdog_armed_reg <= watchdog_armed_next;
            code_history_reg   <= code_history_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg  <= status_code_next;
            m_changed_reg <= changed;
            m_fired_reg   <= fired;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_fired_reg, m_changed_reg, m_status_reg};

    // A tick never both accepts a code and fires the watchdog.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_changed_reg && m_fired_reg))
        else $error("status_changed and watchdog_fired set together");

    // A fired watchdog leaves the status cleared and the watchdog disarmed.
    a_fired_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fired |=> (status_code_reg == '0) && !watchdog_armed_reg)
        else $error("watchdog fired without clearing status");

    // A status change reports a nonzero code equal to the stored status.
    a_changed_code: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && changed |=> (m_status_reg != '0) && (m_status_reg == status_code_reg))
        else $error("status change reported a bad code");

    // A valid burst always rearms the watchdog from zero.
    a_fed_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fed |=> watchdog_armed_reg && (watchdog_count_reg == '0))
        else $error("valid burst did not rearm the watchdog");

    // Every accepted word leaves a result in the output register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word produced no result");

endmodule
